FILE: rtl/core/dbs_pkg.sv
package dbs_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DROPPED  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_READ     = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	localparam int            CUT_W     = 13;
	localparam logic [12:0]   CUT_RESET = 13'd10;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_INS,
		BK_SCAN,
		BK_HEAD,
		BK_ENT
	} bk_state_t;

	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
		logic       has_item;
		logic       last;
		logic [2:0] status;
	} result_t;

endpackage

FILE: rtl/core/dbs_in_if.sv
interface dbs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  poly_col;
	logic [7:0]  poly_row;
	logic [15:0] depth_a;
	logic [15:0] depth_b;
	logic [15:0] depth_c;
	logic [15:0] depth_d;

	modport source (output valid, opcode, poly_col, poly_row, depth_a, depth_b, depth_c,
		depth_d, input ready);
	modport sink (input valid, opcode, poly_col, poly_row, depth_a, depth_b, depth_c,
		depth_d, output ready);
endinterface

FILE: rtl/core/dbs_out_if.sv
interface dbs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_col;
	logic [7:0] out_row;
	logic       has_item;
	logic       last;
	logic [2:0] status;

	modport source (output valid, out_col, out_row, has_item, last, status, input ready);
	modport sink (input valid, out_col, out_row, has_item, last, status, output ready);
endinterface

FILE: rtl/core/dbs_ram.sv
module dbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/dbs_front.sv
module dbs_front
	import dbs_pkg::*;
#(
	parameter int BUCKETS = 8192,
	parameter int CMD_W   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	dbs_in_if.sink           in,
	input  logic             cfg_we,
	input  logic [CUT_W-1:0] cfg_wdata,
	input  logic             q_full,
	output logic             q_push,
	output logic [CMD_W-1:0] q_data
);
	localparam int BW = $clog2(BUCKETS);

	typedef struct packed {
		op_t             op;
		logic            near;
		logic [BW-1:0]   bucket;
		logic [15:0]     ident;
	} cmd_t;

	logic [CUT_W-1:0] cutoff_q;
	logic [17:0]      sum;
	logic [16:0]      avg;
	logic [BW-1:0]    bucket;
	cmd_t             cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUT_RESET;
		end else if (cfg_we) begin
			cutoff_q <= cfg_wdata;
		end
	end

	always_comb begin
		sum = 18'(in.depth_a) + 18'(in.depth_b) + 18'(in.depth_c) + 18'(in.depth_d);
		avg = {1'b0, sum[17:2]};
		// clamp to top bucket
		if (avg > 17'(BUCKETS - 1)) begin
			bucket = BW'(BUCKETS - 1);
		end else begin
			bucket = avg[BW-1:0];
		end
		cmd.op     = op_t'(in.opcode);
		cmd.near   = 17'(bucket) < 17'(cutoff_q);
		cmd.bucket = bucket;
		cmd.ident  = {in.poly_row, in.poly_col};
	end

	assign in.ready = !q_full;
	// unused opcode is swallowed here
	assign q_push = in.valid && !q_full && (cmd.op != OP_NONE);
	assign q_data = CMD_W'(cmd);
endmodule

FILE: rtl/core/dbs_queue.sv
module dbs_queue #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         avail,
	output logic [W-1:0] pop_data
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign full     = cnt_q == 2'd2;
	assign avail    = cnt_q != 2'd0;
	assign pop_data = mem_q[rd_q];
endmodule

FILE: rtl/core/dbs_back.sv
module dbs_back
	import dbs_pkg::*;
#(
	parameter int BUCKETS      = 8192,
	parameter int POOL_ENTRIES = 1024,
	parameter int CMD_W        = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_avail,
	input  logic [CMD_W-1:0] q_data,
	output logic             q_pop,
	dbs_out_if.source        out
);
	localparam int BW = $clog2(BUCKETS);
	localparam int SW = $clog2(BUCKETS + 1);
	localparam int EW = $clog2(POOL_ENTRIES);
	localparam int UW = $clog2(POOL_ENTRIES + 1);
	localparam logic [UW-1:0] EMPTY = UW'(POOL_ENTRIES);

	typedef struct packed {
		op_t             op;
		logic            near;
		logic [BW-1:0]   bucket;
		logic [15:0]     ident;
	} cmd_t;

	cmd_t            cmd;
	bk_state_t       state_q, state_d;
	logic [BW-1:0]   clr_q, clr_d;
	logic [UW-1:0]   used_q, used_d;
	logic [SW-1:0]   scan_b_q, scan_b_d;
	logic [UW-1:0]   scan_e_q, scan_e_d;
	logic            nonempty_q, nonempty_d;
	logic [BW-1:0]   max_q, max_d;
	logic [BW-1:0]   cur_b_q, cur_b_d;
	logic [15:0]     cur_id_q, cur_id_d;
	result_t         res_q, res_d;
	logic            res_v_q, res_v_d;
	logic            res_set;

	logic            h_we;
	logic [BW-1:0]   h_waddr, h_raddr;
	logic [UW-1:0]   h_wdata, h_rdata;
	logic            e_we;
	logic [EW-1:0]   e_waddr, e_raddr;
	logic [UW+15:0]  e_wdata, e_rdata;
	logic [UW-1:0]   nxt;

	assign cmd = cmd_t'(q_data[$bits(cmd_t)-1:0]);

	dbs_ram #(.WIDTH(UW), .DEPTH(BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	dbs_ram #(.WIDTH(UW + 16), .DEPTH(POOL_ENTRIES)) u_entries (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		used_d     = used_q;
		scan_b_d   = scan_b_q;
		scan_e_d   = scan_e_q;
		nonempty_d = nonempty_q;
		max_d      = max_q;
		cur_b_d    = cur_b_q;
		cur_id_d   = cur_id_q;
		res_d      = res_q;
		res_set    = 1'b0;
		q_pop      = 1'b0;
		h_we       = 1'b0;
		h_waddr    = cur_b_q;
		h_wdata    = used_q;
		h_raddr    = cmd.bucket;
		e_we       = 1'b0;
		e_waddr    = used_q[EW-1:0];
		e_wdata    = {h_rdata, cur_id_q};
		e_raddr    = scan_e_q[EW-1:0];
		nxt        = (e_rdata[UW+15:16] >= EMPTY) ? EMPTY : e_rdata[UW+15:16];

		case (state_q)
			BK_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				h_wdata = EMPTY;
				clr_d   = clr_q + 1'b1;
				if (clr_q == BW'(BUCKETS - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_avail && !res_v_q) begin
					q_pop = 1'b1;
					res_d = '0;
					case (cmd.op)
						OP_INSERT: begin
							if (cmd.near) begin
								res_set      = 1'b1;
								res_d.status = ST_DROPPED;
							end else if (used_q >= EMPTY) begin
								res_set      = 1'b1;
								res_d.status = ST_FULL;
							end else begin
								cur_b_d  = cmd.bucket;
								cur_id_d = cmd.ident;
								state_d  = BK_INS;
							end
						end
						OP_READ: begin
							state_d = BK_SCAN;
						end
						default: begin
							// clear: answer now, then sweep the head table
							res_set      = 1'b1;
							res_d.status = ST_CLEARED;
							used_d       = '0;
							scan_b_d     = '0;
							scan_e_d     = EMPTY;
							nonempty_d   = 1'b0;
							clr_d        = '0;
							state_d      = BK_CLEAR;
						end
					endcase
				end
			end
			BK_INS: begin
				e_we       = 1'b1;
				h_we       = 1'b1;
				used_d     = used_q + 1'b1;
				nonempty_d = 1'b1;
				if (!nonempty_q || cur_b_q > max_q) begin
					max_d = cur_b_q;
				end
				res_set      = 1'b1;
				res_d        = '0;
				res_d.status = ST_INSERTED;
				state_d      = BK_IDLE;
			end
			BK_SCAN: begin
				if (scan_e_q < EMPTY) begin
					state_d = BK_ENT;
				end else if (scan_b_q < SW'(BUCKETS) && nonempty_q
						&& scan_b_q <= SW'(max_q)) begin
					h_raddr  = scan_b_q[BW-1:0];
					scan_b_d = scan_b_q + 1'b1;
					state_d  = BK_HEAD;
				end else begin
					// nothing left above: buckets past the highest used one are empty
					scan_b_d     = SW'(BUCKETS);
					res_set      = 1'b1;
					res_d        = '0;
					res_d.status = ST_READ;
					state_d      = BK_IDLE;
				end
			end
			BK_HEAD: begin
				scan_e_d = h_rdata;
				state_d  = BK_SCAN;
			end
			BK_ENT: begin
				scan_e_d       = nxt;
				res_set        = 1'b1;
				res_d.col      = e_rdata[7:0];
				res_d.row      = e_rdata[15:8];
				res_d.has_item = 1'b1;
				res_d.last     = (nxt == EMPTY) && !(nonempty_q && SW'(max_q) >= scan_b_q);
				res_d.status   = ST_READ;
				state_d        = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase

		res_v_d = (res_v_q && !out.ready) || res_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_q      <= '0;
			used_q     <= '0;
			scan_b_q   <= '0;
			scan_e_q   <= EMPTY;
			nonempty_q <= 1'b0;
			max_q      <= '0;
			res_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			used_q     <= used_d;
			scan_b_q   <= scan_b_d;
			scan_e_q   <= scan_e_d;
			nonempty_q <= nonempty_d;
			max_q      <= max_d;
			res_v_q    <= res_v_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_b_q  <= cur_b_d;
		cur_id_q <= cur_id_d;
		res_q    <= res_d;
	end

	assign out.valid    = res_v_q;
	assign out.out_col  = res_q.col;
	assign out.out_row  = res_q.row;
	assign out.has_item = res_q.has_item;
	assign out.last     = res_q.last;
	assign out.status   = res_q.status;

	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !res_v_q)
		else $error("command popped while result slot busy");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR) |-> !q_pop)
		else $error("command popped during clear sweep");
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= EMPTY)
		else $error("pool count overran");
	a_ins_bumps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_INS) |=> (used_q == $past(used_q) + 1'b1))
		else $error("insert did not advance pool");
endmodule

FILE: rtl/core/depth_bucket_sorter_unit.sv
// Depth bucket sorter: sorts quad polygons into depth buckets once per frame.
// Opcode 0 inserts a polygon (average of four corner depths, clamped to the top
// bucket, dropped below near_cutoff), opcode 1 returns the next polygon in
// ascending bucket order (newest first within a bucket), opcode 2 empties the
// table; every such transaction yields exactly one result, opcode 3 yields none.
// A front stage classifies each transaction and a two-entry queue hands it to
// a back sequencer that owns the head table and entry pool RAMs, so input can
// be taken while a result waits. The back sequencer uses registered-read RAMs
// with one write and one read port. An insert writes the entry and bucket head
// in BK_INS; a dropped or pool-full insert is answered from BK_IDLE. A read walks
// BK_SCAN and BK_HEAD, loading bucket heads up to the highest bucket in use,
// and returns a polygon from BK_ENT, or an end result from BK_SCAN. A clear is
// answered at once, then the head table is swept in BK_CLEAR, during which no
// command is started. The same sweep runs after reset. cfg_we writes
// near_cutoff; write it only while the block is idle.
module depth_bucket_sorter_unit
	import dbs_pkg::*;
#(
	parameter int BUCKETS      = 8192,
	parameter int POOL_ENTRIES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	dbs_in_if.sink           in,
	dbs_out_if.source        out,
	input  logic             cfg_we,
	input  logic [CUT_W-1:0] cfg_wdata
);
	// command word: opcode, near flag, bucket, identity
	localparam int CMD_W = 2 + 1 + $clog2(BUCKETS) + 16;

	logic             q_push, q_full, q_pop, q_avail;
	logic [CMD_W-1:0] q_wdata, q_rdata;

	dbs_front #(.BUCKETS(BUCKETS), .CMD_W(CMD_W)) u_front (
		.clk(clk), .arst_n(arst_n), .in(in), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.q_full(q_full), .q_push(q_push), .q_data(q_wdata)
	);

	// decouples classification from table work
	dbs_queue #(.W(CMD_W)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_wdata), .full(q_full),
		.pop(q_pop), .avail(q_avail), .pop_data(q_rdata)
	);

	dbs_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES), .CMD_W(CMD_W)) u_back (
		.clk(clk), .arst_n(arst_n), .q_avail(q_avail), .q_data(q_rdata), .q_pop(q_pop),
		.out(out)
	);
endmodule
